// File: src/bsl_pkg.sv
// bounded sequential list: shared types, opcodes, status codes and the
// command and status structs between controller and datapath
// no dependencies
package bsl_pkg;

   localparam int WORD_W = 32;
   localparam int POS_W  = 5;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_FIND       = 3'd6,
      OP_DUMP       = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    req_type;
      logic signed [WORD_W-1:0]  value;
      logic        [POS_W-1:0]   position;
   } req_item_type;

   typedef struct packed {
      status_type                status;
      logic                      found;
      logic signed [WORD_W-1:0]  element;
      logic        [POS_W-1:0]   index;
      logic        [POS_W-1:0]   length;
      logic                      last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_LOAD_COUNT,
      PTR_LOAD_AT,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      RD_NEXT,
      RD_M1,
      RD_P1
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_AT_COUNT,
      WR_AT_GAP,
      WR_SHIFT
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      HIT_HOLD,
      HIT_CLEAR,
      HIT_LOAD
   } hit_op_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_STATUS,
      RSP_REMOVED,
      RSP_HIT,
      RSP_MISS
   } rsp_op_type;

   typedef struct packed {
      logic        capture;
      logic        at_load;
      logic        elem_load;
      ptr_op_type  ptr_op;
      rd_sel_type  rd_sel;
      wr_op_type   wr_op;
      cnt_op_type  cnt_op;
      hit_op_type  hit_op;
      rsp_op_type  rsp_op;
      status_type  rsp_status;
      logic        rsp_last;
   } cmd_type;

   typedef struct packed {
      op_type  op;
      logic    full;
      logic    empty;
      logic    bad_ins;
      logic    bad_era;
      logic    gap_empty;
      logic    open_last;
      logic    tail1;
      logic    tail2;
      logic    match;
      logic    hit_valid;
   } stat_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_CHECK,
      CS_OPEN_MOVE,
      CS_PLACE,
      CS_CLOSE_LATCH,
      CS_CLOSE_MOVE,
      CS_CLOSE_DONE,
      CS_SCAN,
      CS_SCAN_END
   } ctrl_state_type;

endpackage

// File: src/bsl_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module bsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bsl_datapath.sv
// bounded sequential list datapath: request register, entry count, pointer,
// entry ram, pending hit and the result register
// depends on bsl_pkg and bsl_ram
module bsl_datapath #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsl_pkg::cmd_type      cmd,
   output bsl_pkg::stat_type     stat,
   input  bsl_pkg::req_item_type req_data,
   output logic                  rsp_strobe,
   output bsl_pkg::rsp_item_type rsp_data
);

   localparam int AW   = $clog2(LIST_DEPTH);
   localparam int CW   = $clog2(LIST_DEPTH + 1);
   localparam int CMPW = ((CW > bsl_pkg::POS_W) ? CW : bsl_pkg::POS_W) + 1;

   bsl_pkg::req_item_type req_ff, req_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   ptr_ff, ptr_in;
   logic [AW-1:0]   at_ff, at_in;
   logic [bsl_pkg::WORD_W-1:0] elem_ff, elem_in;
   logic            hit_valid_ff, hit_valid_in;
   logic [bsl_pkg::WORD_W-1:0] hit_el_ff, hit_el_in;
   logic [bsl_pkg::POS_W-1:0]  hit_idx_ff, hit_idx_in;
   bsl_pkg::rsp_item_type rsp_ff, rsp_in;
   logic            strobe_ff, strobe_in;

   logic [CMPW-1:0] pos_w, cnt_w, at_w, ptr_w, ptr_in_w, cnt_in_w;
   logic [CMPW-1:0] gap_at, rd_w, wr_w, at_p1_w, ptr_p1_w;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic            wr_en;
   logic [bsl_pkg::WORD_W-1:0] wr_data, rd_data;

   assign pos_w    = CMPW'(req_ff.position);
   assign cnt_w    = CMPW'(count_ff);
   assign at_w     = CMPW'(at_ff);
   assign ptr_w    = CMPW'(ptr_ff);
   assign ptr_in_w = CMPW'(ptr_in);
   assign cnt_in_w = CMPW'(count_in);
   assign at_p1_w  = at_w + CMPW'(1);
   assign ptr_p1_w = ptr_w + CMPW'(1);

   // place where a gap opens or closes
   always_comb begin
      case (req_ff.req_type)
         bsl_pkg::OP_INSERT,
         bsl_pkg::OP_ERASE:    gap_at = pos_w - CMPW'(1);
         bsl_pkg::OP_POP_BACK: gap_at = cnt_w - CMPW'(1);
         default:              gap_at = '0;
      endcase
   end

   always_comb begin
      stat.op        = req_ff.req_type;
      stat.full      = (cnt_w == CMPW'(LIST_DEPTH));
      stat.empty     = (cnt_w == '0);
      stat.bad_ins   = (pos_w == '0) || (pos_w > cnt_w + CMPW'(1));
      stat.bad_era   = (pos_w == '0) || (pos_w > cnt_w);
      stat.gap_empty = (cnt_w == gap_at);
      stat.open_last = (ptr_w == at_p1_w);
      stat.tail1     = (ptr_p1_w >= cnt_w);
      stat.tail2     = (ptr_w + CMPW'(2) >= cnt_w);
      stat.match     = (req_ff.req_type == bsl_pkg::OP_DUMP) ||
                       (rd_data == req_ff.value);
      stat.hit_valid = hit_valid_ff;
   end

   always_comb begin
      req_in = cmd.capture ? req_data : req_ff;
      at_in  = cmd.at_load ? gap_at[AW-1:0] : at_ff;
      elem_in = cmd.elem_load ? rd_data : elem_ff;

      case (cmd.ptr_op)
         bsl_pkg::PTR_LOAD_COUNT: ptr_in = count_ff;
         bsl_pkg::PTR_LOAD_AT:    ptr_in = gap_at[CW-1:0];
         bsl_pkg::PTR_INC:        ptr_in = ptr_ff + CW'(1);
         bsl_pkg::PTR_DEC:        ptr_in = ptr_ff - CW'(1);
         default:                 ptr_in = ptr_ff;
      endcase

      case (cmd.cnt_op)
         bsl_pkg::CNT_INC: count_in = count_ff + CW'(1);
         bsl_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:          count_in = count_ff;
      endcase

      case (cmd.hit_op)
         bsl_pkg::HIT_CLEAR: begin
            hit_valid_in = 1'b0;
            hit_el_in    = hit_el_ff;
            hit_idx_in   = hit_idx_ff;
         end
         bsl_pkg::HIT_LOAD: begin
            hit_valid_in = 1'b1;
            hit_el_in    = rd_data;
            hit_idx_in   = ptr_p1_w[bsl_pkg::POS_W-1:0];
         end
         default: begin
            hit_valid_in = hit_valid_ff;
            hit_el_in    = hit_el_ff;
            hit_idx_in   = hit_idx_ff;
         end
      endcase
   end

   // ram addressing
   always_comb begin
      case (cmd.rd_sel)
         bsl_pkg::RD_M1: rd_w = ptr_in_w - CMPW'(1);
         bsl_pkg::RD_P1: rd_w = ptr_in_w + CMPW'(1);
         default:        rd_w = ptr_in_w;
      endcase
      rd_addr = rd_w[AW-1:0];

      case (cmd.wr_op)
         bsl_pkg::WR_AT_COUNT: begin
            wr_w    = cnt_w;
            wr_data = req_ff.value;
         end
         bsl_pkg::WR_AT_GAP: begin
            wr_w    = at_w;
            wr_data = req_ff.value;
         end
         default: begin
            wr_w    = ptr_w;
            wr_data = rd_data;
         end
      endcase
      wr_addr = wr_w[AW-1:0];
      wr_en   = (cmd.wr_op != bsl_pkg::WR_NONE);
   end

   // result beat
   always_comb begin
      rsp_in         = rsp_ff;
      strobe_in      = (cmd.rsp_op != bsl_pkg::RSP_NONE);
      case (cmd.rsp_op)
         bsl_pkg::RSP_STATUS: begin
            rsp_in.status  = cmd.rsp_status;
            rsp_in.found   = 1'b0;
            rsp_in.element = '0;
            rsp_in.index   = '0;
            rsp_in.last    = 1'b1;
         end
         bsl_pkg::RSP_REMOVED: begin
            rsp_in.status  = bsl_pkg::ST_OK;
            rsp_in.found   = 1'b0;
            rsp_in.element = elem_ff;
            rsp_in.index   = at_p1_w[bsl_pkg::POS_W-1:0];
            rsp_in.last    = 1'b1;
         end
         bsl_pkg::RSP_HIT: begin
            rsp_in.status  = bsl_pkg::ST_OK;
            rsp_in.found   = 1'b1;
            rsp_in.element = hit_el_ff;
            rsp_in.index   = hit_idx_ff;
            rsp_in.last    = cmd.rsp_last;
         end
         bsl_pkg::RSP_MISS: begin
            rsp_in.status  = bsl_pkg::ST_OK;
            rsp_in.found   = 1'b0;
            rsp_in.element = '0;
            rsp_in.index   = '0;
            rsp_in.last    = 1'b1;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
      if (strobe_in) begin
         rsp_in.length = cnt_in_w[bsl_pkg::POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hit_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         hit_valid_ff <= hit_valid_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      ptr_ff     <= ptr_in;
      at_ff      <= at_in;
      elem_ff    <= elem_in;
      hit_el_ff  <= hit_el_in;
      hit_idx_ff <= hit_idx_in;
      rsp_ff     <= rsp_in;
   end

   bsl_ram #(
      .WIDTH (bsl_pkg::WORD_W),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_w <= CMPW'(LIST_DEPTH))
      else $error("entry count beyond list depth");

   a_no_grow_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == bsl_pkg::CNT_INC) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count did not step by one");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_w < CMPW'(LIST_DEPTH)))
      else $error("ram write outside the list");

endmodule

// File: src/bsl_ctrl.sv
// bounded sequential list controller: sequences checks, gap shifts and scans
// depends on bsl_pkg
module bsl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bsl_pkg::stat_type stat,
   output bsl_pkg::cmd_type  cmd
);

   bsl_pkg::ctrl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsl_pkg::CS_IDLE: begin
            if (start) begin
               state_in = bsl_pkg::CS_CHECK;
            end
         end
         bsl_pkg::CS_CHECK: begin
            case (stat.op)
               bsl_pkg::OP_PUSH_FRONT: begin
                  if (stat.full) state_in = bsl_pkg::CS_IDLE;
                  else if (stat.gap_empty) state_in = bsl_pkg::CS_PLACE;
                  else state_in = bsl_pkg::CS_OPEN_MOVE;
               end
               bsl_pkg::OP_INSERT: begin
                  if (stat.full || stat.bad_ins) state_in = bsl_pkg::CS_IDLE;
                  else if (stat.gap_empty) state_in = bsl_pkg::CS_PLACE;
                  else state_in = bsl_pkg::CS_OPEN_MOVE;
               end
               bsl_pkg::OP_POP_FRONT,
               bsl_pkg::OP_POP_BACK: begin
                  if (stat.empty) state_in = bsl_pkg::CS_IDLE;
                  else state_in = bsl_pkg::CS_CLOSE_LATCH;
               end
               bsl_pkg::OP_ERASE: begin
                  if (stat.empty || stat.bad_era) state_in = bsl_pkg::CS_IDLE;
                  else state_in = bsl_pkg::CS_CLOSE_LATCH;
               end
               bsl_pkg::OP_FIND,
               bsl_pkg::OP_DUMP: begin
                  if (stat.empty) state_in = bsl_pkg::CS_IDLE;
                  else state_in = bsl_pkg::CS_SCAN;
               end
               default: state_in = bsl_pkg::CS_IDLE;
            endcase
         end
         bsl_pkg::CS_OPEN_MOVE: begin
            if (stat.open_last) state_in = bsl_pkg::CS_PLACE;
         end
         bsl_pkg::CS_PLACE:       state_in = bsl_pkg::CS_IDLE;
         bsl_pkg::CS_CLOSE_LATCH: begin
            if (stat.tail1) state_in = bsl_pkg::CS_CLOSE_DONE;
            else state_in = bsl_pkg::CS_CLOSE_MOVE;
         end
         bsl_pkg::CS_CLOSE_MOVE: begin
            if (stat.tail2) state_in = bsl_pkg::CS_CLOSE_DONE;
         end
         bsl_pkg::CS_CLOSE_DONE:  state_in = bsl_pkg::CS_IDLE;
         bsl_pkg::CS_SCAN: begin
            if (stat.tail1) state_in = bsl_pkg::CS_SCAN_END;
         end
         bsl_pkg::CS_SCAN_END:    state_in = bsl_pkg::CS_IDLE;
         default:                 state_in = bsl_pkg::CS_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.ptr_op     = bsl_pkg::PTR_HOLD;
      cmd.rd_sel     = bsl_pkg::RD_NEXT;
      cmd.wr_op      = bsl_pkg::WR_NONE;
      cmd.cnt_op     = bsl_pkg::CNT_HOLD;
      cmd.hit_op     = bsl_pkg::HIT_HOLD;
      cmd.rsp_op     = bsl_pkg::RSP_NONE;
      cmd.rsp_status = bsl_pkg::ST_OK;
      busy           = (state_ff != bsl_pkg::CS_IDLE);
      case (state_ff)
         bsl_pkg::CS_IDLE: begin
            cmd.capture = start;
         end
         bsl_pkg::CS_CHECK: begin
            cmd.at_load = 1'b1;
            cmd.hit_op  = bsl_pkg::HIT_CLEAR;
            case (stat.op)
               bsl_pkg::OP_PUSH_BACK: begin
                  cmd.rsp_op = bsl_pkg::RSP_STATUS;
                  if (stat.full) begin
                     cmd.rsp_status = bsl_pkg::ST_FULL;
                  end else begin
                     cmd.wr_op  = bsl_pkg::WR_AT_COUNT;
                     cmd.cnt_op = bsl_pkg::CNT_INC;
                  end
               end
               bsl_pkg::OP_PUSH_FRONT,
               bsl_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     cmd.rsp_op     = bsl_pkg::RSP_STATUS;
                     cmd.rsp_status = bsl_pkg::ST_FULL;
                  end else if (stat.op == bsl_pkg::OP_INSERT && stat.bad_ins) begin
                     cmd.rsp_op     = bsl_pkg::RSP_STATUS;
                     cmd.rsp_status = bsl_pkg::ST_BAD_POS;
                  end else begin
                     cmd.ptr_op = bsl_pkg::PTR_LOAD_COUNT;
                     cmd.rd_sel = bsl_pkg::RD_M1;
                  end
               end
               bsl_pkg::OP_ERASE: begin
                  if (stat.empty) begin
                     cmd.rsp_op     = bsl_pkg::RSP_STATUS;
                     cmd.rsp_status = bsl_pkg::ST_EMPTY;
                  end else if (stat.bad_era) begin
                     cmd.rsp_op     = bsl_pkg::RSP_STATUS;
                     cmd.rsp_status = bsl_pkg::ST_BAD_POS;
                  end else begin
                     cmd.ptr_op = bsl_pkg::PTR_LOAD_AT;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     cmd.rsp_op     = bsl_pkg::RSP_STATUS;
                     cmd.rsp_status = bsl_pkg::ST_EMPTY;
                  end else begin
                     cmd.ptr_op = bsl_pkg::PTR_LOAD_AT;
                  end
               end
            endcase
         end
         bsl_pkg::CS_OPEN_MOVE: begin
            cmd.wr_op  = bsl_pkg::WR_SHIFT;
            cmd.ptr_op = bsl_pkg::PTR_DEC;
            cmd.rd_sel = bsl_pkg::RD_M1;
         end
         bsl_pkg::CS_PLACE: begin
            cmd.wr_op  = bsl_pkg::WR_AT_GAP;
            cmd.cnt_op = bsl_pkg::CNT_INC;
            cmd.rsp_op = bsl_pkg::RSP_STATUS;
         end
         bsl_pkg::CS_CLOSE_LATCH: begin
            cmd.elem_load = 1'b1;
            cmd.rd_sel    = bsl_pkg::RD_P1;
         end
         bsl_pkg::CS_CLOSE_MOVE: begin
            cmd.wr_op  = bsl_pkg::WR_SHIFT;
            cmd.ptr_op = bsl_pkg::PTR_INC;
            cmd.rd_sel = bsl_pkg::RD_P1;
         end
         bsl_pkg::CS_CLOSE_DONE: begin
            cmd.cnt_op = bsl_pkg::CNT_DEC;
            cmd.rsp_op = bsl_pkg::RSP_REMOVED;
         end
         bsl_pkg::CS_SCAN: begin
            cmd.ptr_op = bsl_pkg::PTR_INC;
            if (stat.match) begin
               cmd.hit_op = bsl_pkg::HIT_LOAD;
               if (stat.hit_valid) begin
                  cmd.rsp_op = bsl_pkg::RSP_HIT;
               end
            end
         end
         bsl_pkg::CS_SCAN_END: begin
            cmd.rsp_last = 1'b1;
            cmd.rsp_op   = stat.hit_valid ? bsl_pkg::RSP_HIT : bsl_pkg::RSP_MISS;
         end
         default: begin
            cmd.capture = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsl_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == bsl_pkg::CS_CHECK))
      else $error("accepted beat not checked");

   a_scan_end_reports: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsl_pkg::CS_SCAN_END) |=> (state_ff == bsl_pkg::CS_IDLE))
      else $error("scan did not finish");

endmodule

// File: src/bounded_sequential_list_core.sv
// bounded sequential list, top level: controller plus datapath with entry ram
// depends on bsl_pkg, bsl_ctrl, bsl_datapath
//
// channel   ports                      handshake
// request   start, busy, req_data      beat taken when start high and busy low
// result    rsp_strobe, rsp_data       one beat per strobe cycle, never held off
//
// push back and any refused request: result beat issued from the check state
// push front and insert: one ram shift per cycle to open the gap, then place
// pop and erase: latch the removed entry, one ram shift per cycle, then done
// find and dump: one entry read per cycle, last beat from the scan end state
// reset clears count, hit flag, strobe, state; entries undefined until written
// busy stays high until the last beat shows, start is ignored meanwhile
module bounded_sequential_list_core #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bsl_pkg::req_item_type req_data,
   output logic                  rsp_strobe,
   output bsl_pkg::rsp_item_type rsp_data
);

   bsl_pkg::cmd_type  cmd;
   bsl_pkg::stat_type stat;

   bsl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bsl_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_last_frees_block: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (busy == !rsp_data.last))
      else $error("last beat and busy disagree");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for bounded_sequential_list_core: directed table then random traffic,
// every result beat compared against its table beat or an in-bench model of the ordered list
// depends on bsl_pkg and the rtl under src

module testbench;

   localparam int LIST_DEPTH = 16;

   typedef struct {
      bsl_pkg::req_item_type item;
      int                    reps;
      logic                  typed;
      bsl_pkg::rsp_item_type beat;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   bsl_pkg::req_item_type req_data;
   logic                  rsp_strobe;
   bsl_pkg::rsp_item_type rsp_data;

   logic                  row_checked;
   bsl_pkg::rsp_item_type row_beat;

   logic signed [bsl_pkg::WORD_W-1:0] list_mem [LIST_DEPTH];
   int unsigned                       list_len;

   bsl_pkg::rsp_item_type predicted_beats[$];
   bsl_pkg::rsp_item_type expected_beats[$];
   stim_row_type          directed_rows[$];

   int   mismatches;
   int   requests_taken;
   int   beats_checked;
   int   full_refusals;
   int   empty_refusals;
   logic [7:0] ops_seen;
   logic idle_enable;

   bounded_sequential_list_core #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** bounded_sequential_list_core: FAILED **");
      $finish;
   end

   function automatic bsl_pkg::rsp_item_type mk_beat(bsl_pkg::status_type st, logic fnd,
                                                     logic signed [bsl_pkg::WORD_W-1:0] el,
                                                     logic [bsl_pkg::POS_W-1:0] idx,
                                                     logic [bsl_pkg::POS_W-1:0] len,
                                                     logic lst);
      bsl_pkg::rsp_item_type b;
      b.status  = st;
      b.found   = fnd;
      b.element = el;
      b.index   = idx;
      b.length  = len;
      b.last    = lst;
      return b;
   endfunction

   function automatic void add_beat(bsl_pkg::status_type st, logic fnd,
                                    logic signed [bsl_pkg::WORD_W-1:0] el,
                                    int unsigned idx, logic lst);
      predicted_beats.push_back(mk_beat(st, fnd, el, bsl_pkg::POS_W'(idx),
                                        bsl_pkg::POS_W'(list_len), lst));
   endfunction

   function automatic void remove_at(int unsigned at);
      int unsigned i;
      for (i = at; i + 1 < list_len; i++) begin
         list_mem[i] = list_mem[i + 1];
      end
      list_len--;
   endfunction

   function automatic void open_at(int unsigned at, logic signed [bsl_pkg::WORD_W-1:0] val);
      int unsigned i;
      for (i = list_len; i > at; i--) begin
         list_mem[i] = list_mem[i - 1];
      end
      list_mem[at] = val;
      list_len++;
   endfunction

   function automatic void predict_list_beats(bsl_pkg::req_item_type it);
      int unsigned                       pos;
      int unsigned                       i;
      int                                hits;
      logic signed [bsl_pkg::WORD_W-1:0] removed;
      pos  = 32'(it.position);
      hits = 0;
      predicted_beats.delete();
      case (it.req_type)
         bsl_pkg::OP_PUSH_BACK, bsl_pkg::OP_PUSH_FRONT: begin
            if (list_len >= LIST_DEPTH) begin
               add_beat(bsl_pkg::ST_FULL, 1'b0, '0, 0, 1'b1);
            end else begin
               open_at((it.req_type == bsl_pkg::OP_PUSH_BACK) ? list_len : 0, it.value);
               add_beat(bsl_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
            end
         end
         bsl_pkg::OP_POP_FRONT, bsl_pkg::OP_POP_BACK: begin
            if (list_len == 0) begin
               add_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 0, 1'b1);
            end else begin
               i = (it.req_type == bsl_pkg::OP_POP_FRONT) ? 0 : list_len - 1;
               removed = list_mem[i];
               remove_at(i);
               add_beat(bsl_pkg::ST_OK, 1'b0, removed, i + 1, 1'b1);
            end
         end
         bsl_pkg::OP_INSERT: begin
            if (list_len >= LIST_DEPTH) begin
               add_beat(bsl_pkg::ST_FULL, 1'b0, '0, 0, 1'b1);
            end else if (pos == 0 || pos > list_len + 1) begin
               add_beat(bsl_pkg::ST_BAD_POS, 1'b0, '0, 0, 1'b1);
            end else begin
               open_at(pos - 1, it.value);
               add_beat(bsl_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
            end
         end
         bsl_pkg::OP_ERASE: begin
            if (list_len == 0) begin
               add_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 0, 1'b1);
            end else if (pos == 0 || pos > list_len) begin
               add_beat(bsl_pkg::ST_BAD_POS, 1'b0, '0, 0, 1'b1);
            end else begin
               removed = list_mem[pos - 1];
               remove_at(pos - 1);
               add_beat(bsl_pkg::ST_OK, 1'b0, removed, pos, 1'b1);
            end
         end
         bsl_pkg::OP_FIND: begin
            if (list_len == 0) begin
               add_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 0, 1'b1);
            end else begin
               for (i = 0; i < list_len; i++) begin
                  if (list_mem[i] == it.value) begin
                     add_beat(bsl_pkg::ST_OK, 1'b1, list_mem[i], i + 1, 1'b0);
                     hits++;
                  end
               end
               if (hits == 0) begin
                  add_beat(bsl_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
               end else begin
                  predicted_beats[hits - 1].last = 1'b1;
               end
            end
         end
         default: begin
            if (list_len == 0) begin
               add_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 0, 1'b1);
            end else begin
               for (i = 0; i < list_len; i++) begin
                  add_beat(bsl_pkg::ST_OK, 1'b1, list_mem[i], i + 1, (i + 1 == list_len));
               end
            end
         end
      endcase
   endfunction

   function automatic logic beat_differs(bsl_pkg::rsp_item_type e, bsl_pkg::rsp_item_type a);
      return (a.status !== e.status) || (a.found !== e.found) ||
             (a.element !== e.element) || (a.index !== e.index) ||
             (a.length !== e.length) || (a.last !== e.last);
   endfunction

   always @(posedge clock) begin
      bsl_pkg::rsp_item_type exp_beat;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected beat: st=%0d f=%0d el=%0d idx=%0d len=%0d last=%0d",
                           rsp_data.status, rsp_data.found, rsp_data.element,
                           rsp_data.index, rsp_data.length, rsp_data.last);
               end
            end else begin
               exp_beat = expected_beats.pop_front();
               beats_checked++;
               if (beat_differs(exp_beat, rsp_data)) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("beat mismatch: exp st=%0d f=%0d el=%0d idx=%0d len=%0d last=%0d",
                              exp_beat.status, exp_beat.found, exp_beat.element,
                              exp_beat.index, exp_beat.length, exp_beat.last);
                     $display("               got st=%0d f=%0d el=%0d idx=%0d len=%0d last=%0d",
                              rsp_data.status, rsp_data.found, rsp_data.element,
                              rsp_data.index, rsp_data.length, rsp_data.last);
                  end
               end
            end
         end
         if (start && !busy) begin
            predict_list_beats(req_data);
            if (predicted_beats[0].status == bsl_pkg::ST_FULL) full_refusals++;
            if (predicted_beats[0].status == bsl_pkg::ST_EMPTY) empty_refusals++;
            if (row_checked) begin
               expected_beats.push_back(row_beat);
            end else begin
               foreach (predicted_beats[k]) expected_beats.push_back(predicted_beats[k]);
            end
            requests_taken++;
            ops_seen[req_data.req_type] = 1'b1;
         end
      end
   end

   task automatic issue(bsl_pkg::req_item_type it, logic chk, bsl_pkg::rsp_item_type b);
      req_data    <= it;
      start       <= 1'b1;
      row_checked <= chk;
      row_beat    <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (idle_enable && $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   function automatic void add_row(bsl_pkg::op_type op, logic signed [bsl_pkg::WORD_W-1:0] val,
                                   logic [bsl_pkg::POS_W-1:0] pos, int reps, logic chk,
                                   bsl_pkg::rsp_item_type b);
      stim_row_type r;
      r.item.req_type = op;
      r.item.value    = val;
      r.item.position = pos;
      r.reps          = reps;
      r.typed         = chk;
      r.beat          = b;
      directed_rows.push_back(r);
   endfunction

   function automatic bsl_pkg::req_item_type random_request(int mode);
      bsl_pkg::req_item_type it;
      int unsigned           r;
      int unsigned           hi;
      r = $urandom_range(0, 99);
      case (mode)
         0: it.req_type = r < 40 ? bsl_pkg::OP_PUSH_BACK : r < 60 ? bsl_pkg::OP_PUSH_FRONT :
                          r < 85 ? bsl_pkg::OP_INSERT : r < 90 ? bsl_pkg::OP_FIND :
                          r < 95 ? bsl_pkg::OP_DUMP : bsl_pkg::op_type'($urandom_range(2, 5));
         1: it.req_type = r < 25 ? bsl_pkg::OP_POP_FRONT : r < 50 ? bsl_pkg::OP_POP_BACK :
                          r < 75 ? bsl_pkg::OP_ERASE : r < 85 ? bsl_pkg::OP_FIND :
                          r < 92 ? bsl_pkg::OP_DUMP : bsl_pkg::op_type'($urandom_range(0, 1));
         default: it.req_type = bsl_pkg::op_type'($urandom_range(0, 7));
      endcase
      r = $urandom_range(0, 9);
      if (r < 5) begin
         it.value = bsl_pkg::WORD_W'($urandom_range(0, 5)) - bsl_pkg::WORD_W'(2);
      end else if (r == 5) begin
         case ($urandom_range(0, 3))
            0: it.value = 32'sh7fff_ffff;
            1: it.value = 32'sh8000_0000;
            2: it.value = '0;
            default: it.value = '1;
         endcase
      end else begin
         it.value = $urandom;
      end
      hi = (it.req_type == bsl_pkg::OP_ERASE) ? list_len : list_len + 1;
      if (hi == 0) hi = 1;
      it.position = ($urandom_range(0, 4) == 0) ? bsl_pkg::POS_W'($urandom_range(0, 31)) :
                                                  bsl_pkg::POS_W'($urandom_range(1, hi));
      return it;
   endfunction

   initial begin
      int mode;
      int kinds;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      row_checked <= 1'b0;
      row_beat    <= '0;
      list_len       = 0;
      mismatches     = 0;
      requests_taken = 0;
      beats_checked  = 0;
      full_refusals  = 0;
      empty_refusals = 0;
      ops_seen       = '0;
      idle_enable    = 1'b1;

      // empty list, bad positions, extremes, mid insert, full list
      add_row(bsl_pkg::OP_POP_FRONT, '0, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 5'd0, 5'd0, 1'b1));
      add_row(bsl_pkg::OP_POP_BACK, '0, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 5'd0, 5'd0, 1'b1));
      add_row(bsl_pkg::OP_ERASE, '0, 5'd1, 1, 1'b1,
              mk_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 5'd0, 5'd0, 1'b1));
      add_row(bsl_pkg::OP_FIND, '0, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 5'd0, 5'd0, 1'b1));
      add_row(bsl_pkg::OP_DUMP, '0, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_EMPTY, 1'b0, '0, 5'd0, 5'd0, 1'b1));
      add_row(bsl_pkg::OP_INSERT, '1, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_BAD_POS, 1'b0, '0, 5'd0, 5'd0, 1'b1));
      add_row(bsl_pkg::OP_INSERT, '1, 5'd2, 1, 1'b1,
              mk_beat(bsl_pkg::ST_BAD_POS, 1'b0, '0, 5'd0, 5'd0, 1'b1));
      add_row(bsl_pkg::OP_PUSH_BACK, 32'sh7fff_ffff, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_OK, 1'b0, '0, 5'd0, 5'd1, 1'b1));
      add_row(bsl_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_OK, 1'b0, '0, 5'd0, 5'd2, 1'b1));
      add_row(bsl_pkg::OP_INSERT, '0, 5'd3, 1, 1'b1,
              mk_beat(bsl_pkg::ST_OK, 1'b0, '0, 5'd0, 5'd3, 1'b1));
      add_row(bsl_pkg::OP_INSERT, '1, 5'd1, 1, 1'b1,
              mk_beat(bsl_pkg::ST_OK, 1'b0, '0, 5'd0, 5'd4, 1'b1));
      add_row(bsl_pkg::OP_ERASE, '0, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_BAD_POS, 1'b0, '0, 5'd0, 5'd4, 1'b1));
      add_row(bsl_pkg::OP_DUMP, '0, 5'd0, 1, 1'b0, '0);
      add_row(bsl_pkg::OP_FIND, 32'sh7fff_ffff, 5'd0, 1, 1'b0, '0);
      add_row(bsl_pkg::OP_FIND, 32'sd12345, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_OK, 1'b0, '0, 5'd0, 5'd4, 1'b1));
      add_row(bsl_pkg::OP_POP_FRONT, '0, 5'd0, 1, 1'b0, '0);
      add_row(bsl_pkg::OP_POP_BACK, '0, 5'd0, 1, 1'b0, '0);
      add_row(bsl_pkg::OP_ERASE, '0, 5'd2, 1, 1'b0, '0);
      add_row(bsl_pkg::OP_PUSH_BACK, 32'sh5a5a_5a5a, 5'd0, LIST_DEPTH - 2, 1'b0, '0);
      add_row(bsl_pkg::OP_INSERT, 32'sh5a5a_5a5a, bsl_pkg::POS_W'(LIST_DEPTH), 1, 1'b0, '0);
      add_row(bsl_pkg::OP_PUSH_BACK, '1, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_FULL, 1'b0, '0, 5'd0, bsl_pkg::POS_W'(LIST_DEPTH), 1'b1));
      add_row(bsl_pkg::OP_PUSH_FRONT, '1, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_FULL, 1'b0, '0, 5'd0, bsl_pkg::POS_W'(LIST_DEPTH), 1'b1));
      add_row(bsl_pkg::OP_INSERT, '1, 5'd0, 1, 1'b1,
              mk_beat(bsl_pkg::ST_FULL, 1'b0, '0, 5'd0, bsl_pkg::POS_W'(LIST_DEPTH), 1'b1));
      add_row(bsl_pkg::OP_FIND, 32'sh5a5a_5a5a, 5'd0, 1, 1'b0, '0);
      add_row(bsl_pkg::OP_DUMP, '0, 5'd0, 1, 1'b0, '0);
      add_row(bsl_pkg::OP_ERASE, '0, bsl_pkg::POS_W'(LIST_DEPTH), 1, 1'b0, '0);
      add_row(bsl_pkg::OP_ERASE, '0, 5'd31, 1, 1'b1,
              mk_beat(bsl_pkg::ST_BAD_POS, 1'b0, '0, 5'd0,
                      bsl_pkg::POS_W'(LIST_DEPTH - 1), 1'b1));
      add_row(bsl_pkg::OP_FIND, 32'sh8000_0000, 5'd0, 1, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         repeat (directed_rows[n].reps) begin
            issue(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].beat);
            maybe_idle();
         end
      end

      mode = 1;
      for (int n = 0; n < 380; n++) begin
         if (n % 40 == 0 && n > 0) mode = $urandom_range(0, 2);
         idle_enable = !(n >= 250 && n < 350);
         if (n == 200) begin
            start <= 1'b0;
            @(posedge clock);
            while (expected_beats.size() != 0 || busy) @(posedge clock);
         end
         issue(random_request(mode), 1'b0, '0);
         maybe_idle();
      end

      start <= 1'b0;
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (expected_beats.size() != 0) mismatches++;

      kinds = $countones(ops_seen);
      $display("run covered %0d requests over %0d of 8 operation kinds, %0d result beats checked",
               requests_taken, kinds, beats_checked);
      $display("full-list refusals %0d, empty-list refusals %0d, mismatches %0d",
               full_refusals, empty_refusals, mismatches);
      if (mismatches == 0) begin
         $display("** bounded_sequential_list_core: PASSED **");
      end else begin
         $display("** bounded_sequential_list_core: FAILED **");
      end
      $finish;
   end

endmodule
